>>> rtl/pnguf_pkg.sv
// ----------------------------------------------------------------------------
// pnguf_pkg
// Shared constants, types and the Paeth predictor for the scanline unfilter.
// ----------------------------------------------------------------------------
package pnguf_pkg;

	localparam int MAX_WIDTH   = 4096;
	localparam int STORE_BYTES = MAX_WIDTH * 4;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int COL_W       = ADDR_W + 1;
	localparam int WIDTH_W     = 13;
	localparam int HEIGHT_W    = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filt_t;

	// One accepted word as it enters the reconstruction stage
	typedef struct packed {
		logic              is_filter;
		logic              bad;
		filt_t             filt;
		logic              row0;
		logic              eor;
		logic              eoi;
		logic [ADDR_W-1:0] pos;
		logic [7:0]        x;
	} item_t;

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [7:0] pa;
		logic [7:0] pb;
		logic [8:0] s;
		logic [8:0] cc;
		logic [8:0] pc;
		pa = (b > c) ? (b - c) : (c - b);
		pb = (a > c) ? (a - c) : (c - a);
		s  = {1'b0, a} + {1'b0, b};
		cc = {c, 1'b0};
		pc = (s > cc) ? (s - cc) : (cc - s);
		if (pa <= pb && {1'b0, pa} <= pc) begin
			return a;
		end else if ({1'b0, pb} <= pc) begin
			return b;
		end
		return c;
	endfunction

endpackage

>>> rtl/png_scanline_unfilter_rgba8.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_rgba8
// PNG filter reconstruction for 8-bit RGBA rows, one stream byte per word.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    data_byte, image_start
//  out      source     out_valid / out_ready  pixel_byte, channel, bad_filter,
//                                             end_of_row, end_of_image
//  cfg      sink       cfg_we                 cfg_index, cfg_data
//
// One word per cycle sustained while the output keeps up; a sample reaches the
// output register through the reconstruction stage (line store read on the
// accepting edge, then reconstruct and write back as that stage advances).
// The line store has no reset and needs no clearing pass; row 0 ignores it.
// A stalled output holds the word in the output register while the next word
// waits in the reconstruction stage; input ready drops only when both are full.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_rgba8 (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pnguf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pnguf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       data_byte,
	input  logic                             image_start,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       pixel_byte,
	output logic [1:0]                       channel,
	output logic                             bad_filter,
	output logic                             end_of_row,
	output logic                             end_of_image
);

	pnguf_pkg::item_t item;
	logic             accept;

	// The sequencer advances its counters on the same edge the word is taken
	assign accept = in_valid && in_ready;

	// Column, row and filter state; decodes each word before it enters the datapath
	pnguf_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.data_byte   (data_byte),
		.image_start (image_start),
		.item        (item)
	);

	// Line store read-modify-write, neighbour bytes and the output register.
	// Reads of a line store entry trail its write by at least a full row plus
	// the filter byte, so no forwarding path is needed.
	pnguf_recon u_recon (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.item         (item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_byte   (pixel_byte),
		.channel      (channel),
		.bad_filter   (bad_filter),
		.end_of_row   (end_of_row),
		.end_of_image (end_of_image)
	);

endmodule

>>> rtl/pnguf_seq.sv
// ----------------------------------------------------------------------------
// pnguf_seq
// Row and column sequencer: configuration, filter byte decode, row edges.
// ----------------------------------------------------------------------------
module pnguf_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pnguf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pnguf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             accept,
	input  logic [7:0]                       data_byte,
	input  logic                             image_start,
	output pnguf_pkg::item_t                 item
);

	logic [pnguf_pkg::COL_W-1:0]    len_q;
	logic [pnguf_pkg::HEIGHT_W-1:0] rows_q;
	logic [pnguf_pkg::COL_W-1:0]    col_q;
	logic [pnguf_pkg::HEIGHT_W-1:0] row_q;
	logic                           row_bad_q;
	pnguf_pkg::filt_t               row_filter_q;

	logic [pnguf_pkg::WIDTH_W-1:0]  w_raw;
	logic [pnguf_pkg::WIDTH_W-1:0]  w_clamp;
	logic [pnguf_pkg::HEIGHT_W-1:0] h_raw;
	logic [pnguf_pkg::COL_W-1:0]    col_eff;
	logic [pnguf_pkg::HEIGHT_W-1:0] row_eff;
	logic [pnguf_pkg::COL_W-1:0]    col_m1;
	logic                           is_filter;
	logic                           bad_byte;
	logic                           last_row;

	// Clamp the width into the range the line store covers
	always_comb begin
		w_raw = cfg_data[pnguf_pkg::WIDTH_W-1:0];
		h_raw = cfg_data[pnguf_pkg::HEIGHT_W-1:0];
		if (w_raw == '0) begin
			w_clamp = pnguf_pkg::WIDTH_W'(1);
		end else if (w_raw > pnguf_pkg::WIDTH_W'(pnguf_pkg::MAX_WIDTH)) begin
			w_clamp = pnguf_pkg::WIDTH_W'(pnguf_pkg::MAX_WIDTH);
		end else begin
			w_clamp = w_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= pnguf_pkg::COL_W'(4);
			rows_q <= pnguf_pkg::HEIGHT_W'(1);
		end else if (cfg_we) begin
			case (pnguf_pkg::cfg_reg_t'(cfg_index))
				pnguf_pkg::CFG_IMAGE_WIDTH: begin
					len_q <= pnguf_pkg::COL_W'(w_clamp) << 2;
				end
				pnguf_pkg::CFG_IMAGE_HEIGHT: begin
					rows_q <= (h_raw == '0) ? pnguf_pkg::HEIGHT_W'(1) : h_raw;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		col_eff   = image_start ? '0 : col_q;
		row_eff   = image_start ? '0 : row_q;
		col_m1    = col_eff - pnguf_pkg::COL_W'(1);
		is_filter = (col_eff == '0);
		bad_byte  = (data_byte > 8'(pnguf_pkg::FILT_PAETH));
		last_row  = ({1'b0, row_eff} + 17'd1) >= {1'b0, rows_q};

		item.is_filter = is_filter;
		item.x         = data_byte;
		item.row0      = (row_eff == '0);
		if (is_filter) begin
			item.bad  = bad_byte;
			item.filt = bad_byte ? pnguf_pkg::FILT_NONE : pnguf_pkg::filt_t'(data_byte[2:0]);
			item.eor  = 1'b0;
			item.eoi  = 1'b0;
			item.pos  = '0;
		end else begin
			item.bad  = row_bad_q;
			item.filt = row_filter_q;
			item.eor  = (col_eff >= len_q);
			item.eoi  = (col_eff >= len_q) && last_row;
			item.pos  = col_m1[pnguf_pkg::ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			row_bad_q    <= 1'b0;
			row_filter_q <= pnguf_pkg::FILT_NONE;
		end else if (accept) begin
			if (is_filter) begin
				row_bad_q    <= item.bad;
				row_filter_q <= item.filt;
				col_q        <= pnguf_pkg::COL_W'(1);
				row_q        <= row_eff;
			end else if (item.eor) begin
				col_q <= '0;
				row_q <= last_row ? '0 : (row_eff + pnguf_pkg::HEIGHT_W'(1));
			end else begin
				col_q <= col_eff + pnguf_pkg::COL_W'(1);
				row_q <= row_eff;
			end
		end
	end

endmodule

>>> rtl/pnguf_recon.sv
// ----------------------------------------------------------------------------
// pnguf_recon
// Line store, neighbour registers, filter arithmetic and output register.
// ----------------------------------------------------------------------------
module pnguf_recon (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pnguf_pkg::item_t item,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       pixel_byte,
	output logic [1:0]       channel,
	output logic             bad_filter,
	output logic             end_of_row,
	output logic             end_of_image
);

	logic [7:0]       mem [pnguf_pkg::STORE_BYTES];
	logic [7:0]       rdata_s1;
	logic             valid_s1;
	pnguf_pkg::item_t item_s1;
	logic [7:0]       left_q [4];
	logic [7:0]       ul_q [4];
	logic             out_v_q;

	logic       accept;
	logic       has_out;
	logic       advance;
	logic [1:0] ch;
	logic [7:0] a;
	logic [7:0] b;
	logic [7:0] c;
	logic [8:0] avg_sum;
	logic [7:0] pred;
	logic [7:0] r;

	assign accept   = in_valid && in_ready;
	assign has_out  = !item_s1.is_filter || item_s1.bad;
	assign advance  = valid_s1 && (!has_out || !out_v_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign out_valid = out_v_q;

	// Read the byte above on accept; the data then waits with its word
	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_s1 <= mem[item.pos];
			item_s1  <= item;
		end
		if (advance && !item_s1.is_filter) begin
			mem[item_s1.pos] <= r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		ch      = item_s1.pos[1:0];
		a       = left_q[ch];
		b       = item_s1.row0 ? 8'd0 : rdata_s1;
		c       = item_s1.row0 ? 8'd0 : ul_q[ch];
		avg_sum = {1'b0, a} + {1'b0, b};
		case (item_s1.filt)
			pnguf_pkg::FILT_NONE:  pred = 8'd0;
			pnguf_pkg::FILT_SUB:   pred = a;
			pnguf_pkg::FILT_UP:    pred = b;
			pnguf_pkg::FILT_AVG:   pred = avg_sum[8:1];
			pnguf_pkg::FILT_PAETH: pred = pnguf_pkg::paeth(a, b, c);
			default:               pred = 8'd0;
		endcase
		r = item_s1.x + pred;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				left_q[i] <= 8'd0;
				ul_q[i]   <= 8'd0;
			end
		end else if (advance) begin
			if (item_s1.is_filter) begin
				for (int i = 0; i < 4; i++) begin
					left_q[i] <= 8'd0;
					ul_q[i]   <= 8'd0;
				end
			end else begin
				left_q[ch] <= r;
				ul_q[ch]   <= b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance && has_out) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_out) begin
			pixel_byte   <= item_s1.is_filter ? 8'd0 : r;
			channel      <= item_s1.is_filter ? 2'd0 : ch;
			bad_filter   <= item_s1.bad;
			end_of_row   <= item_s1.eor;
			end_of_image <= item_s1.eoi;
		end
	end

endmodule

>>> tb/sv/pnguf_tb_pkg.sv
// ----------------------------------------------------------------------------
// pnguf_tb_pkg
// Scoreboard for the RGBA8 scanline unfilter: holds its own copy of the row
// state and line store, predicts each output word and checks it in order.
// ----------------------------------------------------------------------------
package pnguf_tb_pkg;

	import pnguf_pkg::*;

	typedef struct packed {
		logic [7:0] pixel;
		logic [1:0] chan;
		logic       bad;
		logic       eor;
		logic       eoi;
	} sample_word_t;

	class unfilter_scoreboard;

		logic [7:0]   line_store [STORE_BYTES];
		bit           line_written [STORE_BYTES];
		logic [7:0]   left_px [4];
		logic [7:0]   upleft_px [4];
		int unsigned  col;
		int unsigned  row;
		filt_t        filt;
		bit           row_bad;
		logic [12:0]  width_reg;
		logic [15:0]  height_reg;
		sample_word_t expected_q [$];
		int unsigned  mismatches;

		function new();
			for (int i = 0; i < 4; i++) begin
				left_px[i] = '0;
				upleft_px[i] = '0;
			end
			col = 0;
			row = 0;
			filt = FILT_NONE;
			row_bad = 1'b0;
			width_reg = 13'd1;
			height_reg = 16'd1;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [15:0] value);
			if (idx == CFG_IMAGE_WIDTH) begin
				width_reg = value[12:0];
			end else if (idx == CFG_IMAGE_HEIGHT) begin
				height_reg = value;
			end
		endfunction

		function int unsigned row_len();
			int unsigned w;
			w = 32'(width_reg);
			if (w == 0) begin
				w = 1;
			end
			if (w > MAX_WIDTH) begin
				w = MAX_WIDTH;
			end
			return w * 4;
		endfunction

		function bit expecting_filter();
			return col == 0;
		endfunction

		// True when the next sample would fetch a line store byte never written
		function bit would_read_unwritten(logic start);
			int unsigned pos;
			if (start || col == 0) begin
				return 1'b0;
			end
			pos = col - 1;
			return row != 0 && pos < STORE_BYTES && !line_written[pos];
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function logic [7:0] pick_paeth(int a, int b, int c);
			int pa;
			int pb;
			int pc;
			pa = (b > c) ? b - c : c - b;
			pb = (a > c) ? a - c : c - a;
			pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
			if (pa <= pb && pa <= pc) begin
				return a[7:0];
			end else if (pb <= pc) begin
				return b[7:0];
			end
			return c[7:0];
		endfunction

		function void note_input(logic [7:0] x, logic start);
			int unsigned  len;
			int unsigned  pos;
			int unsigned  ch;
			int           a;
			int           b;
			int           c;
			int           r;
			bit           eor;
			bit           last;
			sample_word_t w;
			len = row_len();
			if (start) begin
				row = 0;
				col = 0;
			end
			if (col == 0) begin
				row_bad = x > 8'd4;
				filt = row_bad ? FILT_NONE : filt_t'(x[2:0]);
				for (int i = 0; i < 4; i++) begin
					left_px[i] = '0;
					upleft_px[i] = '0;
				end
				col = 1;
				if (row_bad) begin
					w = '{pixel: 8'd0, chan: 2'd0, bad: 1'b1, eor: 1'b0, eoi: 1'b0};
					expected_q.push_back(w);
				end
				return;
			end
			pos = col - 1;
			ch = pos % 4;
			a = int'(left_px[ch]);
			b = (row != 0 && pos < STORE_BYTES) ? int'(line_store[pos]) : 0;
			c = (row != 0) ? int'(upleft_px[ch]) : 0;
			if (row_bad) begin
				r = int'(x);
			end else begin
				case (filt)
					FILT_SUB:   r = int'(x) + a;
					FILT_UP:    r = int'(x) + b;
					FILT_AVG:   r = int'(x) + ((a + b) >> 1);
					FILT_PAETH: r = int'(x) + int'(pick_paeth(a, b, c));
					default:    r = int'(x);
				endcase
				r = r & 255;
			end
			left_px[ch] = r[7:0];
			upleft_px[ch] = b[7:0];
			if (pos < STORE_BYTES) begin
				line_store[pos] = r[7:0];
				line_written[pos] = 1'b1;
			end
			eor = col >= len;
			last = (row + 1) >= ((height_reg == 0) ? 32'd1 : 32'(height_reg));
			if (eor) begin
				col = 0;
				row = last ? 0 : ((row + 1) & 32'hFFFF);
			end else begin
				col++;
			end
			w = '{pixel: r[7:0], chan: ch[1:0], bad: row_bad, eor: eor, eoi: eor && last};
			expected_q.push_back(w);
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 50) begin
				$display("mismatch at %0t: %s", $realtime, msg);
			end
		endtask

		task check_result(logic [7:0] pix, logic [1:0] ch, logic bad, logic eor,
				logic eoi);
			sample_word_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected word pixel_byte=%0d channel=%0d", pix, ch));
				return;
			end
			want = expected_q.pop_front();
			if (pix !== want.pixel) begin
				report($sformatf("pixel_byte got %0d want %0d", pix, want.pixel));
			end
			if (ch !== want.chan) begin
				report($sformatf("channel got %0d want %0d", ch, want.chan));
			end
			if (bad !== want.bad) begin
				report($sformatf("bad_filter got %0b want %0b", bad, want.bad));
			end
			if (eor !== want.eor) begin
				report($sformatf("end_of_row got %0b want %0b", eor, want.eor));
			end
			if (eoi !== want.eoi) begin
				report($sformatf("end_of_image got %0b want %0b", eoi, want.eoi));
			end
		endtask

	endclass

endpackage

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for png_scanline_unfilter_rgba8: a short directed
// opening over every filter type, then random streams of rows under several
// width/height settings and idling patterns, checked word by word.
// ----------------------------------------------------------------------------
module tb_top;

	import pnguf_pkg::*;
	import pnguf_tb_pkg::*;

	// cycles with no word moving on either channel before giving up
	localparam int QUIET_LIMIT = 2000;
	// receiver hold-off length for the back-pressure phase
	localparam int HOLD_CYCLES = 60;

	// Opening sequence, {image_start, data_byte}, width 1 and height 3:
	// Paeth on the first row, Average, Up to the end of the image, then a new
	// image opening with an invalid filter type, Sub, and None.
	localparam logic [8:0] OPENING [30] = '{
		9'h104, 9'h000, 9'h0FF, 9'h080, 9'h07F,
		9'h003, 9'h001, 9'h0FF, 9'h010, 9'h000,
		9'h002, 9'h0FF, 9'h001, 9'h080, 9'h081,
		9'h105, 9'h012, 9'h034, 9'h056, 9'h078,
		9'h001, 9'h000, 9'h0FF, 9'h055, 9'h0AA,
		9'h000, 9'h0FF, 9'h000, 9'h07E, 9'h001
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            data_byte = '0;
	logic                  image_start = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            pixel_byte;
	logic [1:0]            channel;
	logic                  bad_filter;
	logic                  end_of_row;
	logic                  end_of_image;

	int                 send_idle_pct = 0;
	int                 recv_idle_pct = 0;
	bit                 stall_req = 1'b0;
	int                 hold_left = 0;
	int unsigned        quiet_cycles = 0;
	unfilter_scoreboard sb = new();

	png_scanline_unfilter_rgba8 i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.image_start  (image_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_byte   (pixel_byte),
		.channel      (channel),
		.bad_filter   (bad_filter),
		.end_of_row   (end_of_row),
		.end_of_image (end_of_image)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: drop ready at random, or for a long stretch on request so the
	// two internal stages fill and input ready falls while words keep coming
	always @(negedge clk) begin
		if (stall_req) begin
			stall_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check every output word as it is taken
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(pixel_byte, channel, bad_filter, end_of_row, end_of_image);
		end
	end

	// Watchdog: a hung handshake ends the run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Offer one word and hold it until taken; the scoreboard learns of it at
	// the accepting edge, so the next word can be shaped from fresh state
	task automatic offer_byte(input logic [7:0] d, input logic s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		image_start <= s;
		do @(posedge clk); while (!in_ready);
		sb.note_input(d, s);
		@(negedge clk);
	endtask

	// Wait for every predicted word, then let a trailing filter byte settle
	task automatic settle();
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic reconfigure(input logic [15:0] w, input logic [15:0] h,
			input int s_pct, input int r_pct);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		sb.write_reg(CFG_IMAGE_WIDTH, w);
		@(negedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		sb.write_reg(CFG_IMAGE_HEIGHT, h);
		@(negedge clk);
		cfg_we <= 1'b0;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
	endtask

	// Mostly well-formed rows with random content: a filter byte wherever the
	// block expects one, samples elsewhere, with a little noise and the odd
	// image restart in the middle of a row
	task automatic stream_rows(input int n);
		logic [7:0] d;
		logic       s;
		int         pick;
		for (int i = 0; i < n; i++) begin
			s = ($urandom_range(99) < 2);
			// never let a row beyond the first fetch store bytes not yet written
			if (sb.would_read_unwritten(s)) begin
				s = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 5) begin
				d = 8'($urandom_range(255));
			end else if (s || sb.expecting_filter()) begin
				if (pick < 85) begin
					d = 8'($urandom_range(4));
				end else if (pick < 92) begin
					d = 8'd5;
				end else if (pick < 95) begin
					d = 8'hFF;
				end else begin
					d = 8'($urandom_range(255, 5));
				end
			end else begin
				if (pick < 15) begin
					d = 8'h00;
				end else if (pick < 25) begin
					d = 8'hFF;
				end else begin
					d = 8'($urandom_range(255));
				end
			end
			offer_byte(d, s);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed opening: sender rarely idles, receiver often stalls
		reconfigure(16'd1, 16'd3, 9, 68);
		for (int i = 0; i < 30; i++) begin
			offer_byte(OPENING[i][7:0], OPENING[i][8]);
		end
		in_valid <= 1'b0;

		reconfigure(16'd3, 16'd4, 9, 68);
		stream_rows(350);
		// out-of-range zero width and height act as one
		reconfigure(16'd0, 16'd0, 9, 68);
		stream_rows(150);

		// now the sender idles more than the receiver
		// width above the maximum clamps; only part of one long row is sent
		reconfigure(16'd8191, 16'hFFFF, 68, 9);
		stream_rows(150);
		// narrow mid-row: the current row closes on the next sample
		reconfigure(16'd2, 16'hFFFF, 68, 9);
		stream_rows(300);

		// no idling; upper data bits beyond the width register are ignored
		reconfigure(16'hE005, 16'd2, 0, 0);
		stall_req = 1'b1;
		stream_rows(300);
		reconfigure(16'd4096, 16'd5, 0, 0);
		stream_rows(200);

		settle();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/pnguf_pkg.sv
rtl/pnguf_seq.sv
rtl/pnguf_recon.sv
rtl/png_scanline_unfilter_rgba8.sv
tb/sv/pnguf_tb_pkg.sv
tb/sv/tb_top.sv
